@@ rtl/cfb_pkg.sv @@
// Shared constants, types and the CRC-32/MPEG-2 byte step for the frame core.
`timescale 1ns / 1ps
package cfb_pkg;

  localparam int RX_FRAME_BYTES   = 8;
  localparam int RX_PAYLOAD_BYTES = RX_FRAME_BYTES - 4;
  localparam int RX_POS_W         = $clog2(RX_FRAME_BYTES);

  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
  localparam logic [7:0]  TX_HEADER = 8'hAA;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  localparam logic REQ_RX = 1'b0;
  localparam logic REQ_TX = 1'b1;

  localparam logic [2:0] TX_CRC_WORDS = 3'd4;

  // one result word plus the CRC bytes still to follow it
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        last;
    logic        ok;
    logic [7:0]  command;
    logic [7:0]  process;
    logic [31:0] tail;
    logic [2:0]  count;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      c = {c[30:0], 1'b0} ^ (c[31] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ rtl/cfb_out_stage.sv @@
// Result register: holds one word and steps through the trailing CRC bytes.
`timescale 1ns / 1ps
module cfb_out_stage import cfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_t       load_word,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       frame_ok,
  output logic [7:0] command_code,
  output logic [7:0] process_code
);

  logic ov;
  res_t word;
  logic take;

  assign take = ov && !out_stall;
  assign room = !ov || (take && word.count == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (take && word.count == 3'd0) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end else if (take && word.count != 3'd0) begin
      word.data  <= word.tail[7:0];
      word.tail  <= {8'd0, word.tail[31:8]};
      word.count <= word.count - 3'd1;
      word.last  <= (word.count == 3'd1);
    end
  end

  assign out_valid    = ov;
  assign out_kind     = word.kind;
  assign out_byte     = word.data;
  assign out_last     = word.last;
  assign frame_ok     = word.ok;
  assign command_code = word.command;
  assign process_code = word.process;

  a_load_room: assert property (@(posedge clk) disable iff (rst) load |-> room)
    else $error("result loaded while register busy");
  a_tail_kind: assert property (@(posedge clk) disable iff (rst)
    (ov && word.count != 3'd0) |-> (word.kind == KIND_TX && !word.last))
    else $error("CRC tail on a non-transmit word");
  a_tail_step: assert property (@(posedge clk) disable iff (rst)
    (take && word.count != 3'd0 && !load) |=> (ov && word.count == $past(word.count) - 3'd1))
    else $error("CRC tail did not advance");

endmodule

@@ rtl/crc32_frame_check_and_build_core.sv @@
// Top level of the CRC-32/MPEG-2 frame checker and frame builder.
// One input word is taken per cycle into an input register while in_stall is low
// and is handled there. A receive byte inside a frame causes no output and never
// waits on the output side; the last byte of a receive frame and each transmit
// byte load the one result register. A transmit byte marked last occupies it for
// five output words (the byte, or the header if it opens a frame, then four CRC
// bytes, low byte first), so a following word that loads a result stalls behind
// it; otherwise the rate is one word per cycle, limited only by output stall.
`timescale 1ns / 1ps
module crc32_frame_check_and_build_core import cfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic       payload_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       frame_ok,
  output logic [7:0] command_code,
  output logic [7:0] process_code
);

  localparam logic [RX_POS_W-1:0] POS_LAST    = RX_POS_W'(RX_FRAME_BYTES - 1);
  localparam logic [RX_POS_W-1:0] POS_PAYLOAD = RX_POS_W'(RX_PAYLOAD_BYTES);
  localparam logic [RX_POS_W-1:0] POS_CMD     = RX_POS_W'(1);
  localparam logic [RX_POS_W-1:0] POS_PROC    = RX_POS_W'(2);

  logic       iv;
  logic       in_req;
  logic [7:0] in_data;
  logic       in_plast;

  logic [31:0]         rx_crc;
  logic [RX_POS_W-1:0] rx_position;
  logic                rx_mismatch;
  logic [7:0]          rx_pending_command;
  logic [7:0]          rx_pending_process;
  logic [7:0]          held_command;
  logic [7:0]          held_process;
  logic [31:0]         tx_crc;
  logic                tx_at_start;

  logic                has_result;
  logic                room;
  logic                fire;
  logic                load;
  res_t                load_word;
  logic [31:0]         rx_crc_next;
  logic [31:0]         tx_crc_next;
  logic [1:0]          crc_sel_full;
  logic [7:0]          crc_sel;
  logic                byte_bad;
  logic                frame_end;
  logic                ok;

  assign frame_end  = (rx_position == POS_LAST);
  assign has_result = (in_req == REQ_TX) || frame_end;
  assign fire       = iv && (!has_result || room);
  assign load       = fire && has_result;
  assign in_stall   = iv && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && !in_stall) begin
      iv <= 1'b1;
    end else if (fire) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req   <= req_type;
      in_data  <= data_byte;
      in_plast <= payload_last;
    end
  end

  assign rx_crc_next  = crc_byte(rx_crc, in_data);
  assign tx_crc_next  = crc_byte(tx_crc, in_data);
  assign crc_sel_full = 2'(rx_position - POS_PAYLOAD);

  always_comb begin
    case (crc_sel_full)
      2'd0:    crc_sel = rx_crc[7:0];
      2'd1:    crc_sel = rx_crc[15:8];
      2'd2:    crc_sel = rx_crc[23:16];
      default: crc_sel = rx_crc[31:24];
    endcase
  end

  assign byte_bad = (rx_position >= POS_PAYLOAD) && (crc_sel != in_data);
  assign ok       = !(rx_mismatch || byte_bad);

  always_comb begin
    load_word = '0;
    if (in_req == REQ_TX) begin
      load_word.kind    = KIND_TX;
      load_word.data    = tx_at_start ? TX_HEADER : in_data;
      load_word.last    = !in_plast;
      load_word.ok      = 1'b0;
      load_word.command = held_command;
      load_word.process = held_process;
      load_word.tail    = tx_crc_next;
      load_word.count   = in_plast ? TX_CRC_WORDS : 3'd0;
    end else begin
      load_word.kind    = KIND_RX;
      load_word.data    = 8'd0;
      load_word.last    = 1'b1;
      load_word.ok      = ok;
      load_word.command = ok ? rx_pending_command : held_command;
      load_word.process = ok ? rx_pending_process : held_process;
      load_word.tail    = 32'd0;
      load_word.count   = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_crc             <= CRC_INIT;
      rx_position        <= '0;
      rx_mismatch        <= 1'b0;
      rx_pending_command <= 8'd0;
      rx_pending_process <= 8'd0;
      held_command       <= 8'd0;
      held_process       <= 8'd0;
      tx_crc             <= CRC_INIT;
      tx_at_start        <= 1'b1;
    end else if (fire) begin
      if (in_req == REQ_RX) begin
        if (frame_end) begin
          if (ok) begin
            held_command <= rx_pending_command;
            held_process <= rx_pending_process;
          end
          rx_crc      <= CRC_INIT;
          rx_position <= '0;
          rx_mismatch <= 1'b0;
        end else begin
          if (rx_position < POS_PAYLOAD) begin
            rx_crc <= rx_crc_next;
            if (rx_position == POS_CMD) begin
              rx_pending_command <= in_data;
            end
            if (rx_position == POS_PROC) begin
              rx_pending_process <= in_data;
            end
          end else if (byte_bad) begin
            rx_mismatch <= 1'b1;
          end
          rx_position <= rx_position + RX_POS_W'(1);
        end
      end else begin
        if (in_plast) begin
          tx_crc      <= CRC_INIT;
          tx_at_start <= 1'b1;
        end else begin
          tx_crc      <= tx_crc_next;
          tx_at_start <= 1'b0;
        end
      end
    end
  end

  cfb_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_word    (load_word),
    .room         (room),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .frame_ok     (frame_ok),
    .command_code (command_code),
    .process_code (process_code)
  );

  a_stall_held: assert property (@(posedge clk) disable iff (rst) in_stall |-> (iv && has_result))
    else $error("input stalled without a pending result");
  a_pos_range: assert property (@(posedge clk) disable iff (rst) rx_position <= POS_LAST)
    else $error("receive position out of range");
  a_tx_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && in_req == REQ_TX && in_plast) |=> (tx_at_start && tx_crc == CRC_INIT))
    else $error("transmit state not restarted after last byte");

endmodule
